// ===== src/smc_pkg.sv =====
// shared types and constants of the stack machine calculator
`default_nettype none
package smc_pkg;
  localparam int DEPTH_DEF = 32;
  localparam int MAX_OUT   = 32;
  localparam int DATA_W    = 32;

  localparam logic [3:0] K_PUSH  = 4'd0;
  localparam logic [3:0] K_POP   = 4'd1;
  localparam logic [3:0] K_ADD   = 4'd2;
  localparam logic [3:0] K_SUB   = 4'd3;
  localparam logic [3:0] K_MUL   = 4'd4;
  localparam logic [3:0] K_DIV   = 4'd5;
  localparam logic [3:0] K_DUP   = 4'd6;
  localparam logic [3:0] K_SWAP  = 4'd7;
  localparam logic [3:0] K_ROLL  = 4'd8;
  localparam logic [3:0] K_CLEAR = 4'd9;
  localparam logic [3:0] K_PRINT = 4'd10;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FEW   = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_ROLL  = 3'd4;
  localparam logic [2:0] ST_OVF   = 3'd5;
  localparam logic [2:0] ST_HALT  = 3'd6;

  // divider request / reply between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== src/stack_machine_calculator.sv =====
// top level of the rpn stack machine calculator
// usage:
//  - in_ channel: one command per beat, tuser = kind, tdata = operand
//  - out_ channel: result beats; tdata = data, tuser packs status, is_data
//    and depth_now, tlast marks the final result beat of a command
//  - commands run one at a time out of a single-port-read stack memory
//    with a registered read; every read, add or write is a step of a
//    small sequencer
//  - div runs 32 quotient steps in the divider; roll moves one entry per
//    cycle; print gives one beat a cycle while the output register is free
//  - a command is taken only when the sequencer is idle; the result sits
//    in an output register, and the next command is taken while it waits,
//    the sequencer holds a new result until the register is free
//  - reset clears the element count and halt flag; memory contents need no
//    clearing since only entries below the count are read
//  - after a fatal error every command gives status halted until reset
//  - receiver stalls simply hold the output register and the sequencer
`default_nettype none
module stack_machine_calculator #(
  parameter int DEPTH = smc_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operand[31:0]
  input  wire logic [3:0]  in_tuser,   // kind[3:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // data[31:0]
  output logic [9:0]       out_tuser,  // status[2:0], is_data[3], depth_now[9:4]
  output logic             out_tlast   // last
);
  import smc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] PMAX = (DEPTH > MAX_OUT) ? CW'(MAX_OUT) : CW'(DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;  // top arrives, read second issued
  localparam logic [3:0] S_OP    = 4'd3;  // second arrives, compute
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SWP   = 4'd5;  // write top slot
  localparam logic [3:0] S_RRD   = 4'd6;  // roll: first entry arrives
  localparam logic [3:0] S_RMV   = 4'd7;  // roll: moved entry arrives
  localparam logic [3:0] S_PRD   = 4'd8;  // print: element arrives
  localparam logic [3:0] S_EMIT  = 4'd9;  // result pending, return to idle
  localparam logic [3:0] S_DUP   = 4'd10;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          halt_r, halt_nxt;
  logic [3:0]    kind_r, kind_nxt;
  logic [31:0]   a_r, a_nxt, hold_r, hold_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // walking index
  logic [CW-1:0] n_r, n_nxt;       // print beats left

  // pending result, handed to output register
  logic          pv_r, pv_nxt;
  logic [2:0]    pst_r, pst_nxt;
  logic [31:0]   pd_r, pd_nxt;
  logic          pis_r, pis_nxt, pl_r, pl_nxt;
  logic [CW-1:0] pdep_r, pdep_nxt;

  logic          ov_r;
  logic [31:0]   od_r;
  logic [2:0]    ost_r;
  logic          ois_r, ol_r;
  logic [5:0]    odep_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic [31:0]   prod;
  logic          take, out_free;

  smc_stack_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  smc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && !pv_r;
  assign take      = in_tvalid && in_tready;
  // only the low word of the product is kept
  assign prod      = hold_r * a_r;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    halt_nxt = halt_r;
    kind_nxt = kind_r;
    a_nxt    = a_r;
    hold_nxt = hold_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    pv_nxt   = pv_r;
    pst_nxt  = pst_r;
    pd_nxt   = pd_r;
    pis_nxt  = pis_r;
    pl_nxt   = pl_r;
    pdep_nxt = pdep_r;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;
    dreq     = '{start: 1'b0, num: hold_r, den: a_r};

    if (pv_r && out_free) begin
      pv_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (take) begin
          kind_nxt = in_tuser;
          pv_nxt   = 1'b1;
          pst_nxt  = ST_OK;
          pd_nxt   = '0;
          pis_nxt  = 1'b0;
          pl_nxt   = 1'b1;
          raddr    = AW'(cnt_r - CW'(1));
          if (halt_r) begin
            pst_nxt = ST_HALT;
          end else begin
            case (in_tuser)
              K_PUSH: begin
                if (cnt_r == FULL) begin
                  pst_nxt = ST_OVF;
                end else begin
                  we      = 1'b1;
                  waddr   = AW'(cnt_r);
                  wdata   = in_tdata;
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              K_POP: begin
                if (cnt_r == '0) pst_nxt = ST_EMPTY;
                else cnt_nxt = cnt_r - CW'(1);
              end
              K_ADD, K_SUB, K_MUL, K_DIV, K_SWAP: begin
                if (cnt_r < CW'(2)) begin
                  pst_nxt = ST_FEW;
                end else begin
                  pv_nxt = 1'b0;
                  st_nxt = S_RDA;
                end
              end
              K_DUP: begin
                if (cnt_r == '0) pst_nxt = ST_FEW;
                else if (cnt_r == FULL) pst_nxt = ST_OVF;
                else begin
                  pv_nxt = 1'b0;
                  st_nxt = S_DUP;
                end
              end
              K_ROLL: begin
                if (in_tdata[31] || in_tdata == '0 ||
                    in_tdata > {{(32-CW){1'b0}}, cnt_r}) begin
                  pst_nxt = ST_ROLL;
                end else if (in_tdata == 32'd1) begin
                  pst_nxt = ST_OK;
                end else begin
                  idx_nxt = cnt_r - CW'(in_tdata);
                  raddr   = AW'(cnt_r - CW'(in_tdata));
                  pv_nxt  = 1'b0;
                  st_nxt  = S_RRD;
                end
              end
              K_CLEAR: cnt_nxt = '0;
              K_PRINT: begin
                if (cnt_r != '0) begin
                  pv_nxt  = 1'b0;
                  idx_nxt = cnt_r - CW'(1);
                  n_nxt   = (cnt_r > PMAX) ? PMAX : cnt_r;
                  st_nxt  = S_PRD;
                end
              end
              default: ;
            endcase
            if (pst_nxt >= ST_FEW && pst_nxt != ST_HALT) begin
              halt_nxt = 1'b1;
              cnt_nxt  = '0;
            end
          end
          pdep_nxt = cnt_nxt;
        end
      end
      S_DUP: begin
        we       = 1'b1;
        waddr    = AW'(cnt_r);
        wdata    = rdata;
        cnt_nxt  = cnt_r + CW'(1);
        pv_nxt   = 1'b1;
        pdep_nxt = cnt_r + CW'(1);
        st_nxt   = S_EMIT;
      end
      S_RDA: begin
        a_nxt  = rdata;
        raddr  = AW'(cnt_r - CW'(2));
        st_nxt = S_OP;
      end
      S_OP: begin
        hold_nxt = rdata;
        st_nxt   = S_EMIT;
        pv_nxt   = 1'b1;
        pdep_nxt = cnt_r - CW'(1);
        case (kind_r)
          K_ADD: begin
            we = 1'b1; waddr = AW'(cnt_r - CW'(2)); wdata = rdata + a_r;
            cnt_nxt = cnt_r - CW'(1);
          end
          K_SUB: begin
            we = 1'b1; waddr = AW'(cnt_r - CW'(2)); wdata = rdata - a_r;
            cnt_nxt = cnt_r - CW'(1);
          end
          K_MUL: begin
            pv_nxt = 1'b0;
            st_nxt = S_DIV;
          end
          K_DIV: begin
            if (a_r == '0) begin
              pst_nxt  = ST_DIVZ;
              halt_nxt = 1'b1;
              cnt_nxt  = '0;
              pdep_nxt = '0;
            end else begin
              pv_nxt = 1'b0;
              dreq   = '{start: 1'b1, num: rdata, den: a_r};
              st_nxt = S_DIV;
            end
          end
          default: begin // swap: old top goes to second slot
            we = 1'b1; waddr = AW'(cnt_r - CW'(2)); wdata = a_r;
            pv_nxt = 1'b0;
            st_nxt = S_SWP;
          end
        endcase
      end
      S_DIV: begin
        if (kind_r == K_MUL || drsp.done) begin
          we      = 1'b1;
          waddr   = AW'(cnt_r - CW'(2));
          wdata   = (kind_r == K_MUL) ? prod : drsp.quot;
          cnt_nxt = cnt_r - CW'(1);
          pv_nxt  = 1'b1;
          st_nxt  = S_EMIT;
        end
      end
      S_SWP: begin
        we       = 1'b1;
        waddr    = AW'(cnt_r - CW'(1));
        wdata    = hold_r;
        pv_nxt   = 1'b1;
        pdep_nxt = cnt_r;
        st_nxt   = S_EMIT;
      end
      S_RRD: begin
        // the rolled value is held while the entries above shift down
        hold_nxt = rdata;
        raddr    = AW'(idx_r + CW'(1));
        st_nxt   = S_RMV;
      end
      S_RMV: begin
        we      = 1'b1;
        waddr   = AW'(idx_r);
        wdata   = rdata;
        idx_nxt = idx_r + CW'(1);
        raddr   = AW'(idx_r + CW'(2));
        if (idx_r + CW'(2) == cnt_r) begin
          // final move: the held value lands on top next
          st_nxt  = S_SWP;
        end
      end
      S_PRD: begin
        if (!pv_r || out_free) begin
          pv_nxt   = 1'b1;
          pst_nxt  = ST_OK;
          pd_nxt   = rdata;
          pis_nxt  = 1'b1;
          pl_nxt   = (n_r == CW'(1));
          pdep_nxt = cnt_r;
          n_nxt    = n_r - CW'(1);
          idx_nxt  = idx_r - CW'(1);
          raddr    = AW'(idx_r - CW'(1));
          st_nxt   = (n_r == CW'(1)) ? S_IDLE : S_PRD;
        end else begin
          raddr = AW'(idx_r);
        end
      end
      S_EMIT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      halt_r <= 1'b0;
      pv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      halt_r <= halt_nxt;
      pv_r   <= pv_nxt;
      if (pv_r && out_free) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    kind_r <= kind_nxt;
    a_r    <= a_nxt;
    hold_r <= hold_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    pst_r  <= pst_nxt;
    pd_r   <= pd_nxt;
    pis_r  <= pis_nxt;
    pl_r   <= pl_nxt;
    pdep_r <= pdep_nxt;
    if (pv_r && out_free) begin
      od_r   <= pd_r;
      ost_r  <= pst_r;
      ois_r  <= pis_r;
      ol_r   <= pl_r;
      odep_r <= 6'(pdep_r);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {odep_r, ois_r, ost_r};
  assign out_tlast  = ol_r;

  // a halted machine keeps an empty stack
  a_halt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> cnt_r == '0) else $error("halted with elements");
  // count never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("count past depth");
  // a printed beat always carries ok status
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ois_r) |-> ost_r == ST_OK) else $error("bad print status");
endmodule
`default_nettype wire

// ===== src/smc_div.sv =====
// signed 32-bit divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module smc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smc_pkg::div_req_t req,
  output smc_pkg::div_rsp_t      rsp
);
  import smc_pkg::*;

  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[30:0], quo_r[31]};
    trial    = {1'b0, shifted} - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      quo_nxt  = req.num[31] ? (32'd0 - req.num) : req.num;
      den_nxt  = req.den[31] ? (32'd0 - req.den) : req.den;
      neg_nxt  = req.num[31] ^ req.den[31];
    end else if (busy_r) begin
      // restoring step: quotient bits fill in from the bottom
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (32'd0 - quo_r) : quo_r;
endmodule
`default_nettype wire

// ===== src/smc_stack_ram.sv =====
// stack storage, one write port and one registered read port
`default_nettype none
module smc_stack_ram #(
  parameter int DEPTH = smc_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
